// File: src/pidae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidae_pkg
// Types, register indexes, widths and clamp helpers for the PID regulator.
// ----------------------------------------------------------------------------
package pidae_pkg;

  // field widths
  localparam int unsigned GainW   = 32;
  localparam int unsigned ValW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned IntegW  = 40;
  localparam int unsigned SumW    = 52;
  localparam int unsigned TruncW  = SumW - FracW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // item command codes
  typedef enum logic [1:0] {
    CMD_COMPUTE = 2'd0,
    CMD_AUTO    = 2'd1,
    CMD_MANUAL  = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4,
    REG_PERIOD     = 3'd5,
    REG_REVERSE    = 3'd6
  } reg_idx_t;

  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [ValW-1:0]   val_t;
  typedef logic signed [IntegW-1:0] integ_t;

  // reset values
  localparam val_t             OutMinRst = 16'sd0;
  localparam val_t             OutMaxRst = 16'sd255;
  localparam logic [ValW-1:0]  PeriodRst = 16'd10;

  // clamp a Q.16 value to limits given as integers, upper limit tested first
  function automatic sum_t clamp_q(input sum_t x, input val_t lo, input val_t hi);
    sum_t hi_q;
    sum_t lo_q;
    hi_q = {{(SumW-ValW-FracW){hi[ValW-1]}}, hi, {FracW{1'b0}}};
    lo_q = {{(SumW-ValW-FracW){lo[ValW-1]}}, lo, {FracW{1'b0}}};
    if (x > hi_q) begin
      clamp_q = hi_q;
    end else if (x < lo_q) begin
      clamp_q = lo_q;
    end else begin
      clamp_q = x;
    end
  endfunction

  // clamp an integer value to the limits, upper limit tested first
  function automatic val_t clamp_i(input logic signed [TruncW-1:0] x,
                                   input val_t lo, input val_t hi);
    logic signed [TruncW-1:0] hi_e;
    logic signed [TruncW-1:0] lo_e;
    hi_e = {{(TruncW-ValW){hi[ValW-1]}}, hi};
    lo_e = {{(TruncW-ValW){lo[ValW-1]}}, lo};
    if (x > hi_e) begin
      clamp_i = hi;
    end else if (x < lo_e) begin
      clamp_i = lo;
    end else begin
      clamp_i = x[ValW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: src/pid_abs_error_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_abs_error_controller
// Sampled PID regulator, derivative on measurement, integral and drive
// clamping, proportional and integral terms on the absolute error.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    cmd, now_ms, measured, setpoint,
//                                            manual_output
//  out_      output     out_valid/out_ready  computed, drive, auto_mode
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One request per cycle sustained while out_ready is high; out_valid rises
//  once its request has passed the input register, then the result register.
//  The three gain products, integral clamp and drive clamp sit in the single
//  stage between the input register and the result register.
//  Reset (rst_n low, synchronous) empties both registers and loads the
//  register defaults; no clearing pass. cfg_ready is always high.
//  A stalled result holds the result register; the input register still
//  takes a request when the result register is free or being drained.
// ----------------------------------------------------------------------------
module pid_abs_error_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic [pidae_pkg::TimeW-1:0]     in_now_ms,
  input  wire logic signed [pidae_pkg::ValW-1:0] in_measured,
  input  wire logic signed [pidae_pkg::ValW-1:0] in_setpoint,
  input  wire logic signed [pidae_pkg::ValW-1:0] in_manual_output,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_computed,
  output logic signed [pidae_pkg::ValW-1:0]    out_drive,
  output logic                                 out_auto_mode,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pidae_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [pidae_pkg::CfgDatW-1:0]   cfg_data
);
  import pidae_pkg::*;

  // configuration registers
  logic [GainW-1:0] kp_r, ki_r, kd_r;
  val_t             out_min_r, out_max_r, out_min_nxt, out_max_nxt;
  logic [ValW-1:0]  period_r;
  logic             rev_r;

  // input register
  logic             s1_vld_r;
  cmd_t             s1_cmd_r;
  logic [TimeW-1:0] s1_now_r;
  val_t             s1_meas_r, s1_sp_r, s1_man_r;

  // regulator state
  logic             in_auto_r, in_auto_nxt;
  integ_t           integ_r, integ_nxt;
  val_t             prev_meas_r, prev_meas_nxt;
  logic [TimeW-1:0] prev_time_r, prev_time_nxt;
  logic             first_pend_r, first_pend_nxt;
  val_t             held_drive_r, held_drive_nxt;

  // result register
  logic             out_vld_r;
  logic             out_computed_r;
  val_t             out_drive_r;
  logic             out_auto_r;

  // datapath
  logic                     advance, in_take, cfg_we, lim_wr, fire;
  logic signed [ValW:0]     err_diff, dmeas;
  logic [ValW-1:0]          err_mag;
  logic [GainW+ValW-1:0]    p_prod, i_prod;
  logic signed [GainW+ValW+1:0] d_prod;
  sum_t                     p_ext, i_ext, p_term, i_term, d_term, integ_ext;
  sum_t                     integ_new, sum_all, sum_bias, man_q;
  logic signed [TruncW-1:0] drive_pre;
  val_t                     drive_new;
  logic [TimeW-1:0]         elapsed;

  // handshakes
  assign advance   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || !out_vld_r || out_ready;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  // absolute error and measurement change
  assign err_diff = {s1_sp_r[ValW-1], s1_sp_r} - {s1_meas_r[ValW-1], s1_meas_r};
  assign err_mag  = err_diff[ValW] ? ValW'(-err_diff) : err_diff[ValW-1:0];
  assign dmeas    = {s1_meas_r[ValW-1], s1_meas_r} - {prev_meas_r[ValW-1], prev_meas_r};

  // gain products
  assign p_prod = kp_r * err_mag;
  assign i_prod = ki_r * err_mag;
  assign d_prod = $signed({1'b0, kd_r}) * dmeas;

  // direction and sign extension
  assign p_ext  = {{(SumW-GainW-ValW){1'b0}}, p_prod};
  assign i_ext  = {{(SumW-GainW-ValW){1'b0}}, i_prod};
  assign p_term = rev_r ? -p_ext : p_ext;
  assign i_term = rev_r ? -i_ext : i_ext;
  assign d_term = rev_r ? -sum_t'(d_prod) : sum_t'(d_prod);

  // integral update and drive
  assign integ_ext = {{(SumW-IntegW){integ_r[IntegW-1]}}, integ_r};
  assign integ_new = clamp_q(integ_ext + i_term, out_min_r, out_max_r);
  assign sum_all   = p_term + integ_new - d_term;
  assign sum_bias  = sum_all + (sum_all[SumW-1] ? sum_t'({FracW{1'b1}}) : sum_t'(0));
  assign drive_pre = sum_bias[SumW-1:FracW];
  assign drive_new = clamp_i(drive_pre, out_min_r, out_max_r);

  // sample timing
  assign elapsed = s1_now_r - prev_time_r;
  assign fire    = (s1_cmd_r == CMD_COMPUTE) && in_auto_r &&
                   (first_pend_r || (elapsed >= {{(TimeW-ValW){1'b0}}, period_r}));

  // seed value on entering automatic
  assign man_q = {{(SumW-ValW-FracW){s1_man_r[ValW-1]}}, s1_man_r, {FracW{1'b0}}};

  // limits after a write
  assign lim_wr = cfg_we && ((reg_idx_t'(cfg_index) == REG_OUT_MIN) ||
                             (reg_idx_t'(cfg_index) == REG_OUT_MAX));
  always_comb begin
    out_min_nxt = out_min_r;
    out_max_nxt = out_max_r;
    if (cfg_we && reg_idx_t'(cfg_index) == REG_OUT_MIN) begin
      out_min_nxt = cfg_data[ValW-1:0];
    end
    if (cfg_we && reg_idx_t'(cfg_index) == REG_OUT_MAX) begin
      out_max_nxt = cfg_data[ValW-1:0];
    end
  end

  // next regulator state
  always_comb begin
    in_auto_nxt    = in_auto_r;
    integ_nxt      = integ_r;
    prev_meas_nxt  = prev_meas_r;
    prev_time_nxt  = prev_time_r;
    first_pend_nxt = first_pend_r;
    held_drive_nxt = held_drive_r;
    // limit write in automatic reclamps held values
    if (lim_wr && in_auto_r) begin
      held_drive_nxt = clamp_i({{(TruncW-ValW){held_drive_r[ValW-1]}}, held_drive_r},
                               out_min_nxt, out_max_nxt);
      integ_nxt      = IntegW'(clamp_q(integ_ext, out_min_nxt, out_max_nxt));
    end
    if (advance) begin
      unique case (s1_cmd_r)
        CMD_AUTO: begin
          if (!in_auto_r) begin
            integ_nxt     = IntegW'(clamp_q(man_q, out_min_r, out_max_r));
            prev_meas_nxt = s1_meas_r;
          end
          in_auto_nxt = 1'b1;
        end
        CMD_MANUAL: begin
          in_auto_nxt = 1'b0;
        end
        CMD_COMPUTE: begin
          if (fire) begin
            integ_nxt      = integ_new[IntegW-1:0];
            held_drive_nxt = drive_new;
            prev_meas_nxt  = s1_meas_r;
            prev_time_nxt  = s1_now_r;
            first_pend_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      out_min_r <= OutMinRst;
      out_max_r <= OutMaxRst;
      period_r  <= PeriodRst;
      rev_r     <= 1'b0;
    end else begin
      out_min_r <= out_min_nxt;
      out_max_r <= out_max_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_PROP_GAIN:  kp_r     <= cfg_data;
          REG_INTEG_GAIN: ki_r     <= cfg_data;
          REG_DERIV_GAIN: kd_r     <= cfg_data;
          REG_PERIOD:     period_r <= cfg_data[ValW-1:0];
          REG_REVERSE:    rev_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // regulator state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_auto_r    <= 1'b0;
      integ_r      <= '0;
      prev_meas_r  <= '0;
      prev_time_r  <= '0;
      first_pend_r <= 1'b1;
      held_drive_r <= '0;
    end else begin
      in_auto_r    <= in_auto_nxt;
      integ_r      <= integ_nxt;
      prev_meas_r  <= prev_meas_nxt;
      prev_time_r  <= prev_time_nxt;
      first_pend_r <= first_pend_nxt;
      held_drive_r <= held_drive_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= cmd_t'(in_cmd);
      s1_now_r  <= in_now_ms;
      s1_meas_r <= in_measured;
      s1_sp_r   <= in_setpoint;
      s1_man_r  <= in_manual_output;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_computed_r <= fire;
      out_drive_r    <= held_drive_nxt;
      out_auto_r     <= in_auto_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_computed  = out_computed_r;
  assign out_drive     = out_drive_r;
  assign out_auto_mode = out_auto_r;

  // a computed result always reports automatic mode
  a_computed_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_computed_r |-> out_auto_r)
    else $error("computed result outside automatic mode");

  // with ordered limits the integral stays inside them while automatic
  a_integ_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_auto_r && (out_min_r < out_max_r) |->
      (integ_r <=
        $signed({{(IntegW-ValW-FracW){out_max_r[ValW-1]}}, out_max_r, {FracW{1'b0}}})) &&
      (integ_r >=
        $signed({{(IntegW-ValW-FracW){out_min_r[ValW-1]}}, out_min_r, {FracW{1'b0}}})))
    else $error("integral outside limits");

  // the first-sample flag clears only on a computed sample
  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !first_pend_r && $past(first_pend_r) && $past(rst_n) |-> $past(advance && fire))
    else $error("first-sample flag cleared without a computed sample");

  // a new result comes only from a held request
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !$past(out_vld_r) && $past(rst_n) |-> $past(s1_vld_r))
    else $error("result without a request");

endmodule
`default_nettype wire
